// ===== rtl/core/hbs_pkg.sv =====
// shared types and constants of the height map bilinear sampler
package hbs_pkg;

    // request actions
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_NORMAL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAP_ENABLE = 2'd2;

    // Q1.16 one
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] adj_x;
        logic signed [23:0] adj_y;
        logic [13:0]        write_index;
        logic [16:0]        write_height;
    } t_req;

    typedef struct packed {
        logic [16:0]        height;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_rsp;

endpackage

// ===== rtl/core/heightmap_bilinear_sampler.sv =====
// top level of the height map bilinear sampler
//
// Usage: requests arrive on i_in_valid / o_in_ready with a t_req payload, results
// leave on o_out_valid / i_out_ready with a t_rsp payload. Height entries are
// written by write requests; sample and normal requests give one result each.
// Map size and enable are set over the APB port (0x0 width, 0x4 height,
// 0x8 enable); the user must set them only while no request is in flight, and
// the block does not enforce this. A write request is stored in the height
// memory and leaves the sequencer idle. A sample request runs four position
// products, two row products, four reads of the single read port of the height
// memory and six blend multiplies, all through one shared multiplier; with the
// map disabled it goes straight to its result. A normal request runs four
// samples, three products, a normalizing shift of one bit a cycle, three
// squares, a 32-step bit serial square root and three divisions on one bit
// serial divider; a zero vector ends after the products.
// One request is worked on at a time; o_in_ready is high in the idle state.
// A finished result sits in the output register, so the next request is
// taken while that result waits for a stalled receiver.
// Reset clears the sequencer, the output valid and the registers to width
// 128, height 128, map disabled; the height memory is not cleared.
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FX    = 5'd1;
    localparam logic [4:0] S_FY    = 5'd2;
    localparam logic [4:0] S_WX    = 5'd3;
    localparam logic [4:0] S_WY    = 5'd4;
    localparam logic [4:0] S_R1    = 5'd5;
    localparam logic [4:0] S_R2    = 5'd6;
    localparam logic [4:0] S_RD0   = 5'd7;
    localparam logic [4:0] S_RD1   = 5'd8;
    localparam logic [4:0] S_RD2   = 5'd9;
    localparam logic [4:0] S_RD3   = 5'd10;
    localparam logic [4:0] S_RD4   = 5'd11;
    localparam logic [4:0] S_BL1   = 5'd12;
    localparam logic [4:0] S_BL2   = 5'd13;
    localparam logic [4:0] S_BL3   = 5'd14;
    localparam logic [4:0] S_BL4   = 5'd15;
    localparam logic [4:0] S_BL5   = 5'd16;
    localparam logic [4:0] S_BL6   = 5'd17;
    localparam logic [4:0] S_SEND  = 5'd18;
    localparam logic [4:0] S_V0    = 5'd19;
    localparam logic [4:0] S_V1    = 5'd20;
    localparam logic [4:0] S_V2    = 5'd21;
    localparam logic [4:0] S_MAX   = 5'd22;
    localparam logic [4:0] S_SH    = 5'd23;
    localparam logic [4:0] S_Q0    = 5'd24;
    localparam logic [4:0] S_Q1    = 5'd25;
    localparam logic [4:0] S_Q2    = 5'd26;
    localparam logic [4:0] S_SQ    = 5'd27;
    localparam logic [4:0] S_DV0   = 5'd28;
    localparam logic [4:0] S_DV    = 5'd29;
    localparam logic [4:0] S_DONE  = 5'd30;

    // configuration registers
    logic [7:0] r_map_width;
    logic [7:0] r_map_height;
    logic       r_map_enable;

    // sequencer and datapath registers
    logic [4:0]         r_state;
    logic [1:0]         r_act;
    logic signed [23:0] r_px, r_py, r_ax, r_ay;
    logic [1:0]         r_k;
    logic [1:0]         r_ci;
    logic [4:0]         r_cnt;
    logic [XW-1:0]      r_x1;
    logic [YW-1:0]      r_y1;
    logic [16:0]        r_wx, r_wy;
    logic [AW-1:0]      r_row1, r_row2;
    logic [16:0]        r_mem_q;
    logic [16:0]        r_v [4];
    logic [32:0]        r_acc, r_top;
    logic [63:0]        r_sum;
    logic [16:0]        r_h [4];
    logic [49:0]        r_m [3];
    logic               r_neg [3];
    logic [49:0]        r_mx;
    logic [63:0]        r_sqv, r_res, r_bit;
    logic [30:0]        r_rem;
    logic [16:0]        r_num;
    logic [16:0]        r_q;
    logic signed [15:0] r_n [3];
    logic               r_out_valid;
    t_rsp               r_out;
    logic [16:0]        r_mem [DEPTH];

    // effective map size
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    assign eff_w = (r_map_width == 8'd0) ? WW'(1) :
                   (32'(r_map_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_map_width);
    assign eff_h = (r_map_height == 8'd0) ? HW'(1) :
                   (32'(r_map_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_map_height);

    // neighbor cells clamp to the edge
    logic [XW-1:0] x2;
    logic [YW-1:0] y2;
    assign x2 = ((WW'(r_x1) + WW'(1)) >= eff_w) ? XW'(eff_w - WW'(1)) : XW'(r_x1 + XW'(1));
    assign y2 = ((HW'(r_y1) + HW'(1)) >= eff_h) ? YW'(eff_h - HW'(1)) : YW'(r_y1 + YW'(1));

    // current sample point
    logic signed [24:0] cur_x, cur_y;
    always_comb begin
        cur_x = 25'(r_px);
        cur_y = 25'(r_py);
        if (r_act == ACT_NORMAL) begin
            unique case (r_k)
                2'd0: cur_x = 25'(r_px) - 25'(r_ax);
                2'd1: cur_x = 25'(r_px) + 25'(r_ax);
                2'd2: cur_y = 25'(r_py) - 25'(r_ay);
                2'd3: cur_y = 25'(r_py) + 25'(r_ay);
                default: cur_x = 25'(r_px);
            endcase
        end
    end

    // height differences for the normal
    logic signed [17:0] d_ab, d_cd;
    assign d_ab = $signed({1'b0, r_h[0]}) - $signed({1'b0, r_h[1]});
    assign d_cd = $signed({1'b0, r_h[2]}) - $signed({1'b0, r_h[3]});

    // shared multiplier operand select
    logic signed [33:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [64:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_FX: begin
                mul_a = $signed(34'(cur_x[15:0]));
                mul_b = $signed(31'(eff_w));
            end
            S_FY: begin
                mul_a = $signed(34'(cur_y[15:0]));
                mul_b = $signed(31'(eff_h));
            end
            S_WX: begin
                mul_a = 34'(cur_x);
                mul_b = $signed(31'(eff_w));
            end
            S_WY: begin
                mul_a = 34'(cur_y);
                mul_b = $signed(31'(eff_h));
            end
            S_R1: begin
                mul_a = $signed(34'(r_y1));
                mul_b = $signed(31'(eff_w));
            end
            S_R2: begin
                mul_a = $signed(34'(y2));
                mul_b = $signed(31'(eff_w));
            end
            S_BL1: begin
                mul_a = $signed(34'(r_v[0]));
                mul_b = $signed(31'(ONE_Q16 - r_wx));
            end
            S_BL2: begin
                mul_a = $signed(34'(r_v[1]));
                mul_b = $signed(31'(r_wx));
            end
            S_BL3: begin
                mul_a = $signed(34'(r_v[2]));
                mul_b = $signed(31'(ONE_Q16 - r_wx));
            end
            S_BL4: begin
                mul_a = $signed(34'(r_v[3]));
                mul_b = $signed(31'(r_wx));
            end
            S_BL5: begin
                mul_a = $signed(34'(r_top));
                mul_b = $signed(31'(ONE_Q16 - r_wy));
            end
            S_BL6: begin
                mul_a = $signed(34'(r_acc));
                mul_b = $signed(31'(r_wy));
            end
            S_V0: begin
                mul_a = 34'(r_ay);
                mul_b = 31'(d_ab);
            end
            S_V1: begin
                mul_a = 34'(r_ax);
                mul_b = 31'(r_ay);
            end
            S_V2: begin
                mul_a = 34'(r_ax);
                mul_b = 31'(d_cd);
            end
            S_Q0: begin
                mul_a = $signed(34'(r_m[0][29:0]));
                mul_b = $signed(31'(r_m[0][29:0]));
            end
            S_Q1: begin
                mul_a = $signed(34'(r_m[1][29:0]));
                mul_b = $signed(31'(r_m[1][29:0]));
            end
            S_Q2: begin
                mul_a = $signed(34'(r_m[2][29:0]));
                mul_b = $signed(31'(r_m[2][29:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // first cell from the fraction, zero for positions at or below zero
    logic          x_le0, y_le0;
    assign x_le0 = cur_x[24] || (cur_x == 25'sd0);
    assign y_le0 = cur_y[24] || (cur_y == 25'sd0);

    // axis weight clamped to 0..1
    logic signed [64:0] w_raw;
    logic [16:0]        w_clamp;
    always_comb begin
        if (r_state == S_WX) begin
            w_raw = mul_p - $signed({{(49 - XW){1'b0}}, r_x1, 16'b0});
        end else begin
            w_raw = mul_p - $signed({{(49 - YW){1'b0}}, r_y1, 16'b0});
        end
        if (w_raw < 0) begin
            w_clamp = '0;
        end else if (w_raw > 65'sd65536) begin
            w_clamp = ONE_Q16;
        end else begin
            w_clamp = w_raw[16:0];
        end
    end

    // memory read address
    logic [AW-1:0] rd_addr;
    always_comb begin
        unique case (r_state)
            S_RD0:   rd_addr = r_row1 + AW'(r_x1);
            S_RD1:   rd_addr = r_row1 + AW'(x2);
            S_RD2:   rd_addr = r_row2 + AW'(r_x1);
            default: rd_addr = r_row2 + AW'(x2);
        endcase
    end

    // rounded blend result
    logic [63:0] h_round;
    logic [16:0] h_val;
    assign h_round = r_sum + 64'h0000_0000_8000_0000;
    assign h_val   = r_map_enable ? h_round[48:32] : 17'd0;

    // signed vector component magnitude
    logic signed [64:0] v_cur, v_mag;
    always_comb begin
        v_cur = (r_state == S_V1) ? (mul_p <<< 2) : (mul_p <<< 1);
        v_mag = v_cur[64] ? -v_cur : v_cur;
    end

    // largest magnitude
    logic [49:0] mx01, mx_all;
    assign mx01   = (r_m[0] > r_m[1]) ? r_m[0] : r_m[1];
    assign mx_all = (mx01 > r_m[2]) ? mx01 : r_m[2];

    // square root step
    logic [63:0] sq_try;
    assign sq_try = r_res + r_bit;

    // divider setup and step
    logic [30:0] len;
    logic [45:0] div_num;
    logic [31:0] rem2;
    logic        q_bit;
    logic [16:0] q_next;
    assign len     = r_res[30:0];
    assign div_num = {r_m[r_ci][29:0], 15'b0} + 46'(len >> 1);
    assign rem2    = {r_rem, r_num[16]};
    assign q_bit   = rem2 >= {1'b0, len};
    assign q_next  = {r_q[15:0], q_bit};

    // sign restore and saturate
    logic signed [15:0] n_comp;
    always_comb begin
        if (r_neg[r_ci]) begin
            n_comp = 16'(-$signed({1'b0, q_next}));
        end else if (q_next > 17'd32767) begin
            n_comp = 16'sd32767;
        end else begin
            n_comp = $signed(q_next[15:0]);
        end
    end

    logic in_acc, start_smp;
    assign in_acc    = i_in_valid && o_in_ready;
    assign start_smp = r_map_enable;

    // height memory
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_req.action == ACT_WRITE) && (32'(i_in_req.write_index) < DEPTH)) begin
            r_mem[AW'(i_in_req.write_index)] <= (i_in_req.write_height > ONE_Q16) ?
                                                ONE_Q16 : i_in_req.write_height;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 8'd128;
            r_map_height <= 8'd128;
            r_map_enable <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_MAP_WIDTH:  r_map_width  <= pwdata[7:0];
                REG_MAP_HEIGHT: r_map_height <= pwdata[7:0];
                REG_MAP_ENABLE: r_map_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_MAP_WIDTH:  prdata = {24'd0, r_map_width};
            REG_MAP_HEIGHT: prdata = {24'd0, r_map_height};
            REG_MAP_ENABLE: prdata = {31'd0, r_map_enable};
            default:        prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_ci        <= '0;
            r_cnt       <= '0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_k <= '0;
                        if (i_in_req.action == ACT_SAMPLE || i_in_req.action == ACT_NORMAL) begin
                            r_state <= start_smp ? S_FX : S_SEND;
                        end
                    end
                end
                S_FX:  r_state <= S_FY;
                S_FY:  r_state <= S_WX;
                S_WX:  r_state <= S_WY;
                S_WY:  r_state <= S_R1;
                S_R1:  r_state <= S_R2;
                S_R2:  r_state <= S_RD0;
                S_RD0: r_state <= S_RD1;
                S_RD1: r_state <= S_RD2;
                S_RD2: r_state <= S_RD3;
                S_RD3: r_state <= S_RD4;
                S_RD4: r_state <= S_BL1;
                S_BL1: r_state <= S_BL2;
                S_BL2: r_state <= S_BL3;
                S_BL3: r_state <= S_BL4;
                S_BL4: r_state <= S_BL5;
                S_BL5: r_state <= S_BL6;
                S_BL6: r_state <= S_SEND;
                S_SEND: begin
                    if (r_act == ACT_SAMPLE) begin
                        r_state <= S_DONE;
                    end else if (r_k == 2'd3) begin
                        r_state <= S_V0;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= start_smp ? S_FX : S_SEND;
                    end
                end
                S_V0:  r_state <= S_V1;
                S_V1:  r_state <= S_V2;
                S_V2:  r_state <= S_MAX;
                S_MAX: r_state <= (mx_all == '0) ? S_DONE : S_SH;
                S_SH: begin
                    if (r_mx < 50'(64'd1 << 30) && r_mx >= 50'(64'd1 << 29)) begin
                        r_state <= S_Q0;
                    end
                end
                S_Q0:  r_state <= S_Q1;
                S_Q1:  r_state <= S_Q2;
                S_Q2:  r_state <= S_SQ;
                S_SQ: begin
                    if (r_bit[0]) begin
                        r_ci    <= '0;
                        r_state <= S_DV0;
                    end
                end
                S_DV0: begin
                    r_cnt   <= '0;
                    r_state <= S_DV;
                end
                S_DV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        if (r_ci == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ci    <= r_ci + 2'd1;
                            r_state <= S_DV0;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_act <= i_in_req.action;
                    r_px  <= i_in_req.pos_x;
                    r_py  <= i_in_req.pos_y;
                    r_ax  <= i_in_req.adj_x;
                    r_ay  <= i_in_req.adj_y;
                end
            end
            S_FX:  r_x1 <= x_le0 ? '0 : mul_p[16 +: XW];
            S_FY:  r_y1 <= y_le0 ? '0 : mul_p[16 +: YW];
            S_WX:  r_wx <= w_clamp;
            S_WY:  r_wy <= w_clamp;
            S_R1:  r_row1 <= mul_p[AW-1:0];
            S_R2:  r_row2 <= mul_p[AW-1:0];
            S_RD1: r_v[0] <= r_mem_q;
            S_RD2: r_v[1] <= r_mem_q;
            S_RD3: r_v[2] <= r_mem_q;
            S_RD4: r_v[3] <= r_mem_q;
            S_BL1: r_acc <= mul_p[32:0];
            S_BL2: r_top <= r_acc + mul_p[32:0];
            S_BL3: r_acc <= mul_p[32:0];
            S_BL4: r_acc <= r_acc + mul_p[32:0];
            S_BL5: r_sum <= 64'(mul_p[49:0]);
            S_BL6: r_sum <= r_sum + 64'(mul_p[49:0]);
            S_SEND: r_h[r_k] <= h_val;
            S_V0: begin
                r_m[0]   <= v_mag[49:0];
                r_neg[0] <= v_cur[64];
            end
            S_V1: begin
                r_m[1]   <= v_mag[49:0];
                r_neg[1] <= v_cur[64];
            end
            S_V2: begin
                r_m[2]   <= v_mag[49:0];
                r_neg[2] <= v_cur[64];
            end
            S_MAX: begin
                r_mx <= mx_all;
                for (int i = 0; i < 3; i++) begin
                    r_n[i] <= '0;
                end
            end
            S_SH: begin
                // one bit a cycle toward [2^29, 2^30)
                if (r_mx >= 50'(64'd1 << 30)) begin
                    r_mx <= r_mx >> 1;
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end else if (r_mx < 50'(64'd1 << 29)) begin
                    r_mx <= r_mx << 1;
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            S_Q0: r_sum <= 64'(mul_p[59:0]);
            S_Q1: r_sum <= r_sum + 64'(mul_p[59:0]);
            S_Q2: begin
                r_sqv <= r_sum + 64'(mul_p[59:0]);
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            S_SQ: begin
                // one result bit a cycle
                if (r_sqv >= sq_try) begin
                    r_sqv <= r_sqv - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DV0: begin
                r_rem <= 31'(div_num[45:17]);
                r_num <= div_num[16:0];
                r_q   <= '0;
            end
            S_DV: begin
                r_rem <= q_bit ? 31'(rem2 - {1'b0, len}) : rem2[30:0];
                r_num <= r_num << 1;
                r_q   <= q_next;
                if (r_cnt == 5'd16) begin
                    r_n[r_ci] <= n_comp;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_act == ACT_SAMPLE) begin
                        r_out.height   <= r_h[0];
                        r_out.normal_x <= '0;
                        r_out.normal_y <= '0;
                        r_out.normal_z <= '0;
                    end else begin
                        r_out.height   <= '0;
                        r_out.normal_x <= r_n[0];
                        r_out.normal_y <= r_n[1];
                        r_out.normal_z <= r_n[2];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

// ===== rtl/core/hbs_checker.sv =====
// port level checks of the height map bilinear sampler
module hbs_checker
    import hbs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_rsp
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled result changed");

    // blended height never exceeds one
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.height <= ONE_Q16)
        else $error("height above one");

    // a height result carries no normal
    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.height != 17'd0 |->
            o_out_rsp.normal_x == 16'sd0 && o_out_rsp.normal_y == 16'sd0 &&
            o_out_rsp.normal_z == 16'sd0)
        else $error("height and normal both set");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

// ===== test/heightmap_bilinear_sampler_tb.sv =====
// testbench of the height map bilinear sampler: directed table, random phases, predictor check
module heightmap_bilinear_sampler_tb;
    import hbs_pkg::*;

    localparam int  STORE_DEPTH = 128 * 128;
    localparam int  HOLD_CYCLES = 600;
    localparam int  TAIL_CYCLES = 250;
    localparam int  SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_req        in_req = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_rsp        o_out_rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    heightmap_bilinear_sampler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [16:0] hmap_model [STORE_DEPTH];
    bit          hmap_written [STORE_DEPTH];
    logic [7:0]  cfg_width = 8'd128;
    logic [7:0]  cfg_height = 8'd128;
    logic        cfg_enable = 1'b0;

    t_rsp pending_rsp [$];
    int   mismatches = 0;
    int   failures = 0;
    bit   calm = 1'b0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   out_wait = 0;
    longint cycles = 0;

    function automatic longint eff_size(logic [7:0] r, longint mx);
        if (r == 0) return 1;
        if (longint'(r) > mx) return mx;
        return longint'(r);
    endfunction

    function automatic longint first_cell(longint p, longint s);
        longint c;
        if (p <= 0) return 0;
        c = ((p & 64'hFFFF) * s) / 65536;
        if (c > s - 1) c = s - 1;
        return c;
    endfunction

    function automatic longint axis_weight(longint p, longint s, longint c1);
        longint w;
        w = p * s - c1 * 65536;
        if (w < 0) w = 0;
        if (w > 65536) w = 65536;
        return w;
    endfunction

    function automatic longint cell_height(longint row, longint col, longint w);
        longint idx;
        idx = row * w + col;
        if (idx < 0 || idx >= STORE_DEPTH) return 0;
        return longint'(hmap_model[idx]);
    endfunction

    // bilinear blend of the four cells around a position
    function automatic longint blend_height(longint px, longint py);
        longint w, h, x1, y1, x2, y2, rx, ry, top, bot, sum;
        if (!cfg_enable) return 0;
        w = eff_size(cfg_width, 128);
        h = eff_size(cfg_height, 128);
        x1 = first_cell(px, w);
        y1 = first_cell(py, h);
        x2 = (x1 + 1 > w - 1) ? w - 1 : x1 + 1;
        y2 = (y1 + 1 > h - 1) ? h - 1 : y1 + 1;
        rx = axis_weight(px, w, x1);
        ry = axis_weight(py, h, y1);
        top = cell_height(y1, x1, w) * (65536 - rx) + cell_height(y1, x2, w) * rx;
        bot = cell_height(y2, x1, w) * (65536 - rx) + cell_height(y2, x2, w) * rx;
        sum = top * (65536 - ry) + bot * ry;
        return (sum + (longint'(1) << 31)) >>> 32;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    // unit normal from four samples around the position
    function automatic t_rsp surface_normal(longint px, longint py, longint ax, longint ay);
        longint ha, hb, hc, hd, mx, len, q;
        longint v [3];
        longint m [3];
        bit     neg [3];
        t_rsp   r;
        r = '0;
        ha = blend_height(px - ax, py);
        hb = blend_height(px + ax, py);
        hc = blend_height(px, py - ay);
        hd = blend_height(px, py + ay);
        v[0] = 2 * ay * (ha - hb);
        v[1] = 4 * ax * ay;
        v[2] = 2 * ax * (hc - hd);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return r;
        while (mx >= (longint'(1) << 30)) begin
            mx = mx >>> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
        end
        while (mx < (longint'(1) << 29)) begin
            mx = mx <<< 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
        end
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 32768 + len / 2) / len;
            if (neg[i]) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            v[i] = q;
        end
        r.normal_x = v[0][15:0];
        r.normal_y = v[1][15:0];
        r.normal_z = v[2][15:0];
        return r;
    endfunction

    // apply one accepted request to the model, return its result if any
    function automatic bit predict_result(t_req r, output t_rsp rsp);
        logic [16:0] hv;
        rsp = '0;
        case (r.action)
            ACT_WRITE: begin
                hv = (r.write_height > ONE_Q16) ? ONE_Q16 : r.write_height;
                hmap_model[r.write_index] = hv;
                hmap_written[r.write_index] = 1'b1;
                return 1'b0;
            end
            ACT_SAMPLE: begin
                rsp.height = 17'(blend_height(longint'(r.pos_x), longint'(r.pos_y)));
                return 1'b1;
            end
            ACT_NORMAL: begin
                rsp = surface_normal(longint'(r.pos_x), longint'(r.pos_y),
                                     longint'(r.adj_x), longint'(r.adj_y));
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check, then random or long stalls
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        bit   took;
        took = out_ready && o_out_valid;
        if (took) begin
            if (pending_rsp.size() == 0) begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result %h at cycle %0d", o_out_rsp, cycles);
                mismatches++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_out_rsp.height !== exp_rsp.height
                        || o_out_rsp.normal_x !== exp_rsp.normal_x
                        || o_out_rsp.normal_y !== exp_rsp.normal_y
                        || o_out_rsp.normal_z !== exp_rsp.normal_z) begin
                    failures++;
                    if (mismatches < 10)
                        $display("mismatch at cycle %0d: exp h=%0d n=%0d,%0d,%0d got h=%0d n=%0d,%0d,%0d",
                                 cycles, exp_rsp.height, exp_rsp.normal_x, exp_rsp.normal_y,
                                 exp_rsp.normal_z, o_out_rsp.height, o_out_rsp.normal_x,
                                 o_out_rsp.normal_y, o_out_rsp.normal_z);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n) begin
            out_wait = 0;
        end else if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            out_wait = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (took) begin
            out_wait = calm ? 0 : $urandom_range(0, 15);
            if (out_wait != 0) out_ready <= 1'b0;
        end else if (!out_ready) begin
            if (out_wait == 0) out_ready <= 1'b1;
            else out_wait--;
        end
    end

    // offer one request, predict it once accepted
    task automatic send_req(t_req r, bit typed, t_rsp typed_rsp);
        int   gap;
        t_rsp rsp;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_result(r, rsp)) pending_rsp.push_back(typed ? typed_rsp : rsp);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAP_WIDTH:  cfg_width = value[7:0];
            REG_MAP_HEIGHT: cfg_height = value[7:0];
            REG_MAP_ENABLE: cfg_enable = value[0];
            default: ;
        endcase
    endtask

    function automatic t_req mk_req(logic [1:0] act, int px, int py, int ax, int ay,
                                    int idx, int hgt);
        t_req r;
        r.action = act;
        r.pos_x = px[23:0];
        r.pos_y = py[23:0];
        r.adj_x = ax[23:0];
        r.adj_y = ay[23:0];
        r.write_index = idx[13:0];
        r.write_height = hgt[16:0];
        return r;
    endfunction

    function automatic t_rsp mk_normal(int nx, int ny, int nz);
        t_rsp r;
        r = '0;
        r.normal_x = nx[15:0];
        r.normal_y = ny[15:0];
        r.normal_z = nz[15:0];
        return r;
    endfunction

    function automatic int rand_pos();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2, 3, 4: return $urandom_range(0, 65535);
            5, 6: return int'({{8{1'b0}}, 24'($urandom)}) - (1 << 23);
            7: return -int'($urandom_range(0, 65535));
            8: begin
                case ($urandom_range(0, 3))
                    0: return 8388607;
                    1: return -8388608;
                    2: return 0;
                    default: return 65536;
                endcase
            end
            default: return $urandom_range(65536, 400000);
        endcase
    endfunction

    function automatic int rand_adj();
        int a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                a = $urandom_range(0, 8192);
                return $urandom_range(0, 1) ? -a : a;
            end
            6: return 0;
            7, 8: return int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
            default: return $urandom_range(0, 1) ? 8388607 : -8388608;
        endcase
    endfunction

    // one setting of the registers, then preload and random requests
    task automatic run_phase(int w, int h, bit en, int n_items, bit quiet, bit long_hold);
        longint cells;
        int     act;
        int     idx;
        int     hgt;
        t_req   r;
        drain();
        apb_write(REG_MAP_WIDTH, w);
        apb_write(REG_MAP_HEIGHT, h);
        apb_write(REG_MAP_ENABLE, {31'd0, en});
        calm = quiet;
        cells = eff_size(cfg_width, 128) * eff_size(cfg_height, 128);
        // every cell of the active map is written before it can be read
        for (int i = 0; i < cells; i++)
            if (!hmap_written[i])
                send_req(mk_req(ACT_WRITE, 0, 0, 0, 0, i, $urandom_range(0, 65536)), 0, '0);
        if (long_hold) hold_asks++;
        for (int n = 0; n < n_items; n++) begin
            act = $urandom_range(0, 19);
            idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, cells - 1)
                                              : $urandom_range(0, STORE_DEPTH - 1);
            hgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(0, 65536);
            r = mk_req(ACT_WRITE, rand_pos(), rand_pos(), rand_adj(), rand_adj(), idx, hgt);
            if (act < 6) r.action = ACT_WRITE;
            else if (act < 12) r.action = ACT_SAMPLE;
            else if (act < 19) r.action = ACT_NORMAL;
            else r.action = 2'd3;
            send_req(r, 0, '0);
        end
    endtask

    // directed table
    t_req dir_req [$];
    bit   dir_typed [$];
    t_rsp dir_rsp [$];

    task automatic add_row(t_req r, bit typed, t_rsp rsp);
        dir_req.push_back(r);
        dir_typed.push_back(typed);
        dir_rsp.push_back(rsp);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // map disabled after reset: heights read zero
        add_row(mk_req(ACT_SAMPLE, 0, 0, 0, 0, 0, 0), 1, '0);
        add_row(mk_req(ACT_SAMPLE, 8388607, -8388608, 0, 0, 0, 0), 1, '0);
        add_row(mk_req(ACT_SAMPLE, -8388608, 8388607, 8388607, -8388608, 0, 0), 1, '0);
        // zero vector
        add_row(mk_req(ACT_NORMAL, 1000, 2000, 0, 0, 0, 0), 1, '0);
        add_row(mk_req(ACT_NORMAL, 1000, 2000, 0, 500, 0, 0), 1, '0);
        // flat map: normal points straight along y, saturated
        add_row(mk_req(ACT_NORMAL, 0, 0, 1, 1, 0, 0), 1, mk_normal(0, 32767, 0));
        add_row(mk_req(ACT_NORMAL, 0, 0, -1, 1, 0, 0), 1, mk_normal(0, -32768, 0));
        add_row(mk_req(ACT_NORMAL, 8388607, -8388608, 8388607, -8388608, 0, 0), 1,
                mk_normal(0, -32768, 0));
        add_row(mk_req(ACT_NORMAL, -8388608, 8388607, -8388608, -8388608, 0, 0), 1,
                mk_normal(0, 32767, 0));
        // writes: top index, clamped height, zero, one
        add_row(mk_req(ACT_WRITE, 0, 0, 0, 0, 16383, 131071), 0, '0);
        add_row(mk_req(ACT_WRITE, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(ACT_WRITE, 0, 0, 0, 0, 1, 65536), 0, '0);
        add_row(mk_req(ACT_WRITE, 0, 0, 0, 0, 2, 65537), 0, '0);
        add_row(mk_req(ACT_WRITE, 0, 0, 0, 0, 3, 12345), 0, '0);
        // unused action: no result, then one predicted sample
        add_row(mk_req(2'd3, 8388607, 8388607, 8388607, 8388607, 16383, 131071), 0, '0);
        add_row(mk_req(ACT_SAMPLE, 32768, 32768, 0, 0, 0, 0), 0, '0);
        for (int i = 0; i < dir_req.size(); i++) send_req(dir_req[i], dir_typed[i], dir_rsp[i]);

        // small map, a map of one cell, edge shapes, size clamps and a disabled map
        run_phase(2, 2, 1, 120, 0, 0);
        run_phase(4, 3, 1, 180, 1, 1);
        run_phase(128, 2, 1, 180, 0, 0);
        run_phase(2, 128, 1, 170, 0, 0);
        run_phase(0, 255, 1, 150, 0, 0);
        run_phase(255, 0, 1, 150, 1, 0);
        run_phase(7, 5, 0, 100, 0, 0);
        run_phase(16, 16, 1, 200, 0, 1);
        run_phase(1, 1, 1, 130, 0, 0);

        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== heightmap_bilinear_sampler.f =====
rtl/core/hbs_pkg.sv
rtl/core/heightmap_bilinear_sampler.sv
rtl/core/hbs_checker.sv
test/heightmap_bilinear_sampler_tb.sv
